// ----- rtl/psync_pkg.sv -----
// ----------------------------------------------------------------------------
// psync_pkg - shared types and constants for the phase sync oscillator
// Widths of the shared divider, step counts and the command/status structs
// that pass between the sequencer and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

package psync_pkg;

   // Field widths
   localparam int TIME_W   = 32;
   localparam int TIMER_W  = 16;
   localparam int SUM_W    = 48;
   localparam int COUNT_W  = 16;
   localparam int CORR_W   = 17;

   // Shared divider: dividend/quotient shift register, partial remainder
   localparam int DIV_W    = 49;
   localparam int REM_W    = 32;
   localparam int STEP_W   = 6;

   localparam logic [STEP_W-1:0]  ROUND_STEPS   = STEP_W'(DIV_W);
   localparam logic [STEP_W-1:0]  SHORT_STEPS   = STEP_W'(TIMER_W);

   localparam logic [TIMER_W-1:0] NOMINAL_RESET = 16'd256;
   localparam logic [TIMER_W-1:0] TIMER_MAX     = 16'hFFFF;
   localparam logic [COUNT_W-1:0] COUNT_MAX     = 16'hFFFF;

   localparam logic [SUM_W-1:0]   SUM_POS_LIMIT = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic [SUM_W-1:0]   SUM_NEG_LIMIT = {1'b1, {(SUM_W-1){1'b0}}};

   // Divider launch command
   typedef struct packed {
      logic               start;
      logic [STEP_W-1:0]  steps;
      logic [REM_W-1:0]   rem_init;
      logic [DIV_W-1:0]   dividend;
      logic [REM_W-1:0]   divisor;
   } psync_div_cmd_type;

   // Divider status
   typedef struct packed {
      logic               done;
      logic [DIV_W-1:0]   quotient;
      logic [REM_W-1:0]   remainder;
   } psync_div_rsp_type;

endpackage

`default_nettype wire

// ----- rtl/psync_if.sv -----
// ----------------------------------------------------------------------------
// psync_if - handshake channels of the phase sync oscillator
// Request, response and register write channels, each valid/ready with a
// source and a sink modport.
// ----------------------------------------------------------------------------
`default_nettype none

interface psync_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] now_ticks;
   logic        has_message;
   logic [15:0] neighbour_timer;

   modport source (output valid, output now_ticks, output has_message,
                   output neighbour_timer, input ready);
   modport sink   (input valid, input now_ticks, input has_message,
                   input neighbour_timer, output ready);
endinterface

interface psync_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] elapsed_ticks;
   logic [15:0] period_ticks;
   logic [15:0] phase_fraction;
   logic        period_restarted;

   modport source (output valid, output elapsed_ticks, output period_ticks,
                   output phase_fraction, output period_restarted, input ready);
   modport sink   (input valid, input elapsed_ticks, input period_ticks,
                   input phase_fraction, input period_restarted, output ready);
endinterface

interface psync_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] nominal_period;

   modport source (output valid, output nominal_period, input ready);
   modport sink   (input valid, input nominal_period, output ready);
endinterface

`default_nettype wire

// ----- rtl/psync_div.sv -----
// ----------------------------------------------------------------------------
// psync_div - shared restoring divider
// One quotient bit per cycle. The dividend is loaded at the top of the shift
// register, the partial remainder may be preloaded, and the step count is
// set per command. Quotient bits shift in at the bottom.
// ----------------------------------------------------------------------------
`default_nettype none

module psync_div (
   input  logic                         clock,
   input  logic                         reset,
   input  psync_pkg::psync_div_cmd_type cmd,
   output psync_pkg::psync_div_rsp_type rsp
);
   import psync_pkg::*;

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [DIV_W-1:0]  quo_ff;
   logic [REM_W-1:0]  dvs_ff;

   logic [REM_W:0]    trial;
   logic [REM_W:0]    trial_sub;
   logic              trial_ge;
   logic [REM_W-1:0]  rem_in;

   // Shift in the next dividend bit and try to subtract
   assign trial     = {rem_ff, quo_ff[DIV_W-1]};
   assign trial_sub = trial - {1'b0, dvs_ff};
   assign trial_ge  = (trial >= {1'b0, dvs_ff});
   assign rem_in    = trial_ge ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];

   // Sequence the steps
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= cmd.steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rem_ff <= cmd.rem_init;
         quo_ff <= cmd.dividend;
         dvs_ff <= cmd.divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[DIV_W-2:0], trial_ge};
      end
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

`default_nettype wire

// ----- rtl/phase_sync_oscillator_core.sv -----
// ----------------------------------------------------------------------------
// phase_sync_oscillator_core - pulse-coupled oscillator phase tracker
// Sequencer and state around one shared divider.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one item per software tick: now_ticks, has_message and
//   neighbour_timer. rsp_chan returns exactly one item for each request:
//   elapsed ticks, period length, Q0.16 phase and the restart flag.
//   csr_chan writes nominal_period (reset 256); it is always ready. The user
//   writes it only while no request is in flight; the block does not enforce it.
//   One request is worked on at a time; req_chan.ready is low meanwhile.
//   rsp_chan.valid rises once the item has run through the steps that it
//   needs, the long ones on the one restoring divider:
//     a 49-bit rounded quotient when a new period starts,
//     the direct correction when a message allows it,
//     else the wrap-aware remainder when a message needs it,
//     the phase quotient when it is needed (num < den, den != 0).
//   req_chan.ready returns when the result enters the output register,
//   so a new item is not accepted before the last one is finished.
//   The result waits in an output register: if rsp_chan stalls, a finished
//   item holds there and the next request is still accepted, but its own
//   result is not written until the register frees.
//   Reset (synchronous) clears all timing state, the message accumulator and
//   the count, drops any pending result and restores nominal_period to 256.
// ----------------------------------------------------------------------------
`default_nettype none

module phase_sync_oscillator_core (
   input  logic         clock,
   input  logic         reset,
   psync_req_if.sink    req_chan,
   psync_rsp_if.source  rsp_chan,
   psync_csr_if.sink    csr_chan
);
   import psync_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROUND_GO,
      ST_ROUND_WAIT,
      ST_CORR_GO,
      ST_CORR_WAIT,
      ST_APPLY,
      ST_PHASE_GO,
      ST_PHASE_WAIT,
      ST_FINISH
   } state_type;

   state_type             state_ff;

   logic [TIMER_W-1:0]    nominal_ff;
   logic [TIME_W-1:0]     last_ff;
   logic [TIME_W-1:0]     next_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic [COUNT_W-1:0]    count_ff;

   logic [TIME_W-1:0]     now_ff;
   logic                  msg_ff;
   logic [TIMER_W-1:0]    theirs_ff;
   logic                  restart_ff;
   logic                  corr_neg_ff;
   logic [CORR_W-1:0]     corr_ff;
   logic [TIMER_W-1:0]    phase_ff;

   logic                  rsp_valid_ff;
   logic [TIMER_W-1:0]    rsp_elapsed_ff;
   logic [TIMER_W-1:0]    rsp_period_ff;
   logic [TIMER_W-1:0]    rsp_phase_ff;
   logic                  rsp_restart_ff;

   psync_div_cmd_type     div_cmd;
   psync_div_rsp_type     div_rsp;

   logic [TIME_W-1:0]     req_since;
   logic                  req_restart;

   logic [SUM_W-1:0]      sum_mag;
   logic [COUNT_W:0]      round_div;
   logic [DIV_W-1:0]      round_num;
   logic [TIME_W-1:0]     round_q;

   logic [TIME_W-1:0]     num;
   logic [TIME_W-1:0]     den;
   logic [CORR_W-1:0]     disc;
   logic [TIMER_W-1:0]    mag;
   logic [CORR_W:0]       wrap_diff;
   logic [TIMER_W-1:0]    wrap_mag;
   logic [TIMER_W-1:0]    corr_rem;

   logic [SUM_W:0]        sum_add;
   logic [SUM_W-1:0]      sum_sat;

   // Restart test on the arriving item
   assign req_since   = req_chan.now_ticks - last_ff;
   assign req_restart = (req_chan.now_ticks >= next_ff) || (req_since[TIME_W-1:TIMER_W] != '0);

   // Rounded quotient operands: (2|a| + d) / (2d) with d = 2*count + 1
   assign sum_mag   = sum_ff[SUM_W-1] ? (~sum_ff + 1'b1) : sum_ff;
   assign round_div = {count_ff, 1'b1};
   assign round_num = {sum_mag, 1'b0} + DIV_W'(round_div);
   assign round_q   = sum_ff[SUM_W-1] ? (~div_rsp.quotient[TIME_W-1:0] + 1'b1)
                                      : div_rsp.quotient[TIME_W-1:0];

   // Elapsed time and period length since the last restart
   assign num = now_ff - last_ff;
   assign den = next_ff - last_ff;

   // Neighbour discrepancy and its wrap distance from the nominal period
   assign disc      = {1'b0, theirs_ff} - {1'b0, num[TIMER_W-1:0]};
   assign mag       = disc[CORR_W-1] ? TIMER_W'(~disc + 1'b1) : disc[TIMER_W-1:0];
   assign wrap_diff = {2'b00, nominal_ff} - {2'b00, mag};
   assign wrap_mag  = wrap_diff[CORR_W] ? TIMER_W'(~wrap_diff + 1'b1)
                                        : wrap_diff[TIMER_W-1:0];
   assign corr_rem  = div_rsp.remainder[TIMER_W-1:0];

   // Saturating accumulate of the correction
   assign sum_add = {sum_ff[SUM_W-1], sum_ff} + {{(SUM_W+1-CORR_W){corr_ff[CORR_W-1]}}, corr_ff};
   always_comb begin
      if (sum_add[SUM_W] != sum_add[SUM_W-1]) begin
         sum_sat = sum_add[SUM_W] ? SUM_NEG_LIMIT : SUM_POS_LIMIT;
      end else begin
         sum_sat = sum_add[SUM_W-1:0];
      end
   end

   // Launch the shared divider from the go states
   always_comb begin
      div_cmd = '0;
      unique case (state_ff)
         ST_ROUND_GO: begin
            div_cmd.start    = 1'b1;
            div_cmd.steps    = ROUND_STEPS;
            div_cmd.dividend = round_num;
            div_cmd.divisor  = REM_W'({round_div, 1'b0});
         end
         ST_CORR_GO: begin
            div_cmd.start    = msg_ff && (mag >= (nominal_ff >> 1)) && (nominal_ff != '0);
            div_cmd.steps    = SHORT_STEPS;
            div_cmd.dividend = {wrap_mag, {(DIV_W-TIMER_W){1'b0}}};
            div_cmd.divisor  = REM_W'(nominal_ff);
         end
         ST_PHASE_GO: begin
            div_cmd.start    = (den != '0) && (num < den);
            div_cmd.steps    = SHORT_STEPS;
            div_cmd.rem_init = num;
            div_cmd.divisor  = den;
         end
         default: begin
            div_cmd = '0;
         end
      endcase
   end

   psync_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   // Sequencer, state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         nominal_ff   <= NOMINAL_RESET;
         last_ff      <= '0;
         next_ff      <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_chan.valid) begin
            nominal_ff <= csr_chan.nominal_period;
         end
         // Free the output register once its item is taken
         if (rsp_chan.ready && (state_ff != ST_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_chan.valid) begin
                  now_ff     <= req_chan.now_ticks;
                  msg_ff     <= req_chan.has_message;
                  theirs_ff  <= req_chan.neighbour_timer;
                  restart_ff <= req_restart;
                  state_ff   <= req_restart ? ST_ROUND_GO : ST_CORR_GO;
               end
            end
            ST_ROUND_GO: begin
               state_ff <= ST_ROUND_WAIT;
            end
            ST_ROUND_WAIT: begin
               if (div_rsp.done) begin
                  last_ff  <= now_ff;
                  next_ff  <= now_ff + TIME_W'(nominal_ff) + round_q;
                  sum_ff   <= '0;
                  count_ff <= '0;
                  state_ff <= ST_CORR_GO;
               end
            end
            ST_CORR_GO: begin
               priority if (!msg_ff) begin
                  state_ff <= ST_PHASE_GO;
               end else if (mag < (nominal_ff >> 1)) begin
                  corr_ff  <= ~disc + 1'b1;
                  state_ff <= ST_APPLY;
               end else if (nominal_ff == '0) begin
                  corr_ff  <= '0;
                  state_ff <= ST_APPLY;
               end else begin
                  corr_neg_ff <= disc[CORR_W-1] ^ wrap_diff[CORR_W];
                  state_ff    <= ST_CORR_WAIT;
               end
            end
            ST_CORR_WAIT: begin
               if (div_rsp.done) begin
                  corr_ff  <= corr_neg_ff ? (~{1'b0, corr_rem} + 1'b1) : {1'b0, corr_rem};
                  state_ff <= ST_APPLY;
               end
            end
            ST_APPLY: begin
               sum_ff <= sum_sat;
               if (count_ff != COUNT_MAX) begin
                  count_ff <= count_ff + 1'b1;
               end
               state_ff <= ST_PHASE_GO;
            end
            ST_PHASE_GO: begin
               if ((den != '0) && (num < den)) begin
                  state_ff <= ST_PHASE_WAIT;
               end else begin
                  phase_ff <= TIMER_MAX;
                  state_ff <= ST_FINISH;
               end
            end
            ST_PHASE_WAIT: begin
               if (div_rsp.done) begin
                  phase_ff <= div_rsp.quotient[TIMER_W-1:0];
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_elapsed_ff <= num[TIMER_W-1:0];
                  rsp_period_ff  <= den[TIMER_W-1:0];
                  rsp_phase_ff   <= phase_ff;
                  rsp_restart_ff <= restart_ff;
                  state_ff       <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_chan.ready            = (state_ff == ST_IDLE);
   assign csr_chan.ready            = 1'b1;
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.elapsed_ticks    = rsp_elapsed_ff;
   assign rsp_chan.period_ticks     = rsp_period_ff;
   assign rsp_chan.phase_fraction   = rsp_phase_ff;
   assign rsp_chan.period_restarted = rsp_restart_ff;

endmodule

`default_nettype wire

// ----- rtl/psync_checker.sv -----
// ----------------------------------------------------------------------------
// psync_checker - port-level checks for the phase sync oscillator
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module psync_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_elapsed_ticks,
   input logic [15:0] rsp_period_ticks,
   input logic [15:0] rsp_phase_fraction,
   input logic        rsp_period_restarted
);

   // Hold a stalled result item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped while stalled");

   // Keep the payload of a stalled result item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_elapsed_ticks) && $stable(rsp_period_ticks)
         && $stable(rsp_phase_fraction) && $stable(rsp_period_restarted))
      else $error("rsp payload changed while stalled");

   // Drop ready once an item is taken: one item in flight
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // A restarted period reports zero elapsed ticks
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_period_restarted |-> rsp_elapsed_ticks == 16'd0)
      else $error("restart item with nonzero elapsed ticks");

endmodule

bind phase_sync_oscillator_core psync_checker u_psync_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_chan.valid),
   .req_ready            (req_chan.ready),
   .rsp_valid            (rsp_chan.valid),
   .rsp_ready            (rsp_chan.ready),
   .rsp_elapsed_ticks    (rsp_chan.elapsed_ticks),
   .rsp_period_ticks     (rsp_chan.period_ticks),
   .rsp_phase_fraction   (rsp_chan.phase_fraction),
   .rsp_period_restarted (rsp_chan.period_restarted)
);

`default_nettype wire

// ----- tb/tb_phase_sync_oscillator_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_phase_sync_oscillator_core - self-checking bench for the oscillator core
// Walks a short stimulus table and then random tick sequences under several
// nominal periods. Each accepted item updates a local model of the period
// restart, the message accumulator and the phase math. Each returned item is
// compared field by field against the oldest prediction. Both handshakes see
// random gaps and stalls.
// ----------------------------------------------------------------------------

module tb_phase_sync_oscillator_core;

   import psync_pkg::*;

   typedef struct packed {
      logic [31:0] now_ticks;
      logic        has_message;
      logic [15:0] neighbour_timer;
   } tick_item_type;

   typedef struct packed {
      logic [15:0] elapsed_ticks;
      logic [15:0] period_ticks;
      logic [15:0] phase_fraction;
      logic        period_restarted;
   } osc_result_type;

   typedef struct packed {
      logic           is_cfg;
      logic [15:0]    cfg_value;
      tick_item_type  item;
      logic           typed;
      osc_result_type want;
   } stim_row_type;

   localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint SUM_LO = -SUM_HI - 1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   psync_req_if req_bus ();
   psync_rsp_if rsp_bus ();
   psync_csr_if csr_bus ();

   phase_sync_oscillator_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #6 clock = ~clock;

   // Oscillator model state
   logic [15:0]     nom_period;
   logic [31:0]     last_restart;
   logic [31:0]     next_reset;
   longint          adjust_acc;
   int unsigned     msg_count;

   osc_result_type  expected_results [$];
   stim_row_type    stim_rows [$];
   int              err_count;
   int              rsp_seen;
   bit              quiet;
   int              stall_left;

   // Report one mismatch, print only the first few
   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      err_count++;
      if (err_count <= 40)
         $display("mismatch at result %0d, %s: got 0x%0h, expected 0x%0h",
                  rsp_seen, what, got, want);
   endtask

   // Wrap-aware correction from one neighbour timer
   function automatic longint neighbour_correction(input logic [15:0] mine,
                                                   input logic [15:0] theirs);
      longint p, mine_l, theirs_l, disc, mag, sgn, diff, rr;
      p        = nom_period;
      mine_l   = mine;
      theirs_l = theirs;
      disc     = theirs_l - mine_l;
      mag      = (disc < 0) ? -disc : disc;
      sgn      = (disc < 0) ? -1 : 1;
      if (mag < p / 2)
         return -disc;
      if (p == 0)
         return 0;
      diff = p - mag;
      if (diff < 0)
         rr = -((-diff) % p);
      else
         rr = diff % p;
      return sgn * rr;
   endfunction

   // Advance the model by one item and work out its result
   task automatic predict_tick(input tick_item_type it, output osc_result_type r);
      logic [31:0]     el32, num, den;
      logic [63:0]     ph;
      longint unsigned dv, mag_u, q;
      longint          qs;
      logic            restart;
      el32    = it.now_ticks - last_restart;
      restart = (it.now_ticks >= next_reset) || (el32 > 32'h0000_FFFF);
      if (restart) begin
         dv = 2 * msg_count + 1;
         if (adjust_acc < 0)
            mag_u = -adjust_acc;
         else
            mag_u = adjust_acc;
         q  = (2 * mag_u + dv) / (2 * dv);
         qs = q;
         if (adjust_acc < 0)
            qs = -qs;
         last_restart = it.now_ticks;
         next_reset   = it.now_ticks + {16'd0, nom_period} + qs[31:0];
         adjust_acc   = 0;
         msg_count    = 0;
      end
      el32 = it.now_ticks - last_restart;
      if (it.has_message) begin
         if (msg_count < COUNT_MAX)
            msg_count++;
         adjust_acc = adjust_acc + neighbour_correction(el32[15:0], it.neighbour_timer);
         if (adjust_acc > SUM_HI)
            adjust_acc = SUM_HI;
         if (adjust_acc < SUM_LO)
            adjust_acc = SUM_LO;
      end
      num = it.now_ticks - last_restart;
      den = next_reset - last_restart;
      if (den == 32'd0) begin
         ph = TIMER_MAX;
      end else begin
         ph = {num, 16'h0000} / den;
         if (ph > 64'h0000_FFFF)
            ph = TIMER_MAX;
      end
      r.elapsed_ticks    = num[15:0];
      r.period_ticks     = den[15:0];
      r.phase_fraction   = ph[15:0];
      r.period_restarted = restart;
   endtask

   // Sender gap: mostly none or short, a few long
   function automatic int pick_gap();
      int unsigned r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one item, hold until accepted, then record its prediction
   task automatic send_tick(input tick_item_type it, input logic typed,
                            input osc_result_type want);
      osc_result_type pred;
      int             gap;
      req_bus.valid           <= 1'b1;
      req_bus.now_ticks       <= it.now_ticks;
      req_bus.has_message     <= it.has_message;
      req_bus.neighbour_timer <= it.neighbour_timer;
      do @(posedge clock); while (!req_bus.ready);
      predict_tick(it, pred);
      expected_results.push_back(typed ? want : pred);
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drain, then write the nominal period while the block is idle
   task automatic write_nominal(input logic [15:0] value);
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      csr_bus.valid          <= 1'b1;
      csr_bus.nominal_period <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      nom_period = value;
   endtask

   task automatic add_item(input logic [31:0] now, input logic msg,
                           input logic [15:0] theirs);
      stim_row_type row;
      row      = '0;
      row.item = '{now, msg, theirs};
      stim_rows.push_back(row);
   endtask

   task automatic add_typed(input logic [31:0] now, input logic [15:0] e,
                            input logic [15:0] p, input logic [15:0] ph,
                            input logic rs);
      stim_row_type row;
      row       = '0;
      row.item  = '{now, 1'b0, 16'd0};
      row.typed = 1'b1;
      row.want  = '{e, p, ph, rs};
      stim_rows.push_back(row);
   endtask

   task automatic add_cfg(input logic [15:0] value);
      stim_row_type row;
      row           = '0;
      row.is_cfg    = 1'b1;
      row.cfg_value = value;
      stim_rows.push_back(row);
   endtask

   // Check returned items and drive the result ready with random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected item", rsp_bus.elapsed_ticks, 0);
            end else begin
               osc_result_type w;
               w = expected_results.pop_front();
               if (rsp_bus.elapsed_ticks !== w.elapsed_ticks)
                  report_mismatch("elapsed_ticks", rsp_bus.elapsed_ticks, w.elapsed_ticks);
               if (rsp_bus.period_ticks !== w.period_ticks)
                  report_mismatch("period_ticks", rsp_bus.period_ticks, w.period_ticks);
               if (rsp_bus.phase_fraction !== w.phase_fraction)
                  report_mismatch("phase_fraction", rsp_bus.phase_fraction,
                                  w.phase_fraction);
               if (rsp_bus.period_restarted !== w.period_restarted)
                  report_mismatch("period_restarted", rsp_bus.period_restarted,
                                  w.period_restarted);
            end
            rsp_seen++;
         end
         if (quiet) begin
            rsp_bus.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            int unsigned r;
            r = $urandom_range(0, 99);
            if (r < 70) begin
               rsp_bus.ready <= 1'b1;
            end else begin
               rsp_bus.ready <= 1'b0;
               stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(15, 50);
            end
         end
      end
   end

   // Hard stop if the block hangs
   initial begin
      #(20_000_000);
      $display("TB_ERROR");
      $finish;
   end

   // Stimulus
   logic [15:0]   phase_nom [7];
   tick_item_type rnd_item;
   logic [31:0]   cur_now, el_now;
   logic [15:0]   e16;
   int            n, span, half, off;
   int unsigned   sel;
   logic [31:0]   raw;

   initial begin
      req_bus.valid           = 1'b0;
      req_bus.now_ticks       = '0;
      req_bus.has_message     = 1'b0;
      req_bus.neighbour_timer = '0;
      csr_bus.valid           = 1'b0;
      csr_bus.nominal_period  = NOMINAL_RESET;
      rsp_bus.ready           = 1'b0;
      err_count  = 0;
      rsp_seen   = 0;
      quiet      = 1'b0;
      stall_left = 0;

      // Model reset state
      nom_period   = NOMINAL_RESET;
      last_restart = '0;
      next_reset   = '0;
      adjust_acc   = 0;
      msg_count    = 0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // First restart after reset, mid period, last tick, exact restart
      add_typed(32'd0,   16'd0,   16'd256, 16'd0,     1'b1);
      add_typed(32'd128, 16'd128, 16'd256, 16'd32768, 1'b0);
      add_typed(32'd255, 16'd255, 16'd256, 16'd65280, 1'b0);
      add_typed(32'd256, 16'd0,   16'd256, 16'd0,     1'b1);
      // Messages: in phase, behind, far ahead, exactly half a period, wrapped
      add_item(32'd300, 1'b1, 16'd44);
      add_item(32'd310, 1'b1, 16'd0);
      add_item(32'd320, 1'b1, 16'hFFFF);
      add_item(32'd330, 1'b1, 16'd202);
      add_item(32'd340, 1'b1, 16'd65492);
      // Restart with accumulated adjustment, then time running backward
      add_item(32'd512, 1'b0, 16'd0);
      add_item(32'd10,  1'b0, 16'd0);
      // Zero period register and zero period length
      add_cfg(16'd0);
      add_item(32'd2000, 1'b1, 16'd7);
      add_item(32'd2000, 1'b0, 16'd0);
      add_item(32'd2001, 1'b0, 16'd0);
      // Largest register, restart on elapsed overflow
      add_cfg(16'hFFFF);
      add_item(32'd5000,  1'b1, 16'd40000);
      add_item(32'd75000, 1'b0, 16'd0);
      // Smallest legal period across the 32-bit wrap
      add_cfg(16'd4);
      add_item(32'hFFFF_FF00, 1'b1, 16'd0);
      add_item(32'hFFFF_FFFF, 1'b1, 16'd3);
      add_item(32'h0000_0002, 1'b0, 16'd0);
      // Largest legal period, half-period boundary
      add_cfg(16'd32768);
      add_item(32'h8000_0000, 1'b1, 16'd16384);
      add_item(32'h8000_0100, 1'b1, 16'hFFFF);

      foreach (stim_rows[i]) begin
         if (stim_rows[i].is_cfg)
            write_nominal(stim_rows[i].cfg_value);
         else
            send_tick(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].want);
      end

      // Random tick sequences under several periods
      phase_nom[0] = NOMINAL_RESET;
      phase_nom[1] = 16'd4;
      phase_nom[2] = 16'd32768;
      phase_nom[3] = 16'($urandom_range(4, 32768));
      phase_nom[4] = 16'd1;
      phase_nom[5] = 16'hFFFF;
      phase_nom[6] = 16'($urandom_range(4, 64));
      cur_now = 32'h0000_1000;

      for (int ph = 0; ph < 7; ph++) begin
         write_nominal(phase_nom[ph]);
         quiet = (ph == 2);
         n     = phase_nom[ph];
         for (int k = 0; k < 93; k++) begin
            // Advance time: mostly small steps, some jumps and noise
            sel = $urandom_range(0, 99);
            if (sel < 80)
               cur_now = cur_now + $urandom_range(0, (n >> 3) + 2);
            else if (sel < 87)
               cur_now = $urandom;
            else if (sel < 92)
               cur_now = cur_now - $urandom_range(1, 1000);
            else if (sel < 96)
               cur_now = 32'hFFFF_FFFF - $urandom_range(0, 600);
            else
               cur_now = cur_now + $urandom_range(65000, 70000);

            // Neighbour timer near own elapsed, on the half-period edge, or random
            el_now = cur_now - last_restart;
            e16    = el_now[15:0];
            span   = ((n < 2000) ? n : 2000) + 1;
            half   = n / 2;
            sel    = $urandom_range(0, 99);
            if (sel < 45) begin
               off = $urandom_range(0, 2 * span);
               off = off - span;
               rnd_item.neighbour_timer = e16 + off[15:0];
            end else if (sel < 60) begin
               case ($urandom_range(0, 3))
                  0: off = half;
                  1: off = -half;
                  2: off = half - 1;
                  default: off = 1 - half;
               endcase
               rnd_item.neighbour_timer = e16 + off[15:0];
            end else if (sel < 85) begin
               raw = $urandom;
               rnd_item.neighbour_timer = raw[15:0];
            end else if (sel < 92) begin
               rnd_item.neighbour_timer = 16'd0;
            end else begin
               rnd_item.neighbour_timer = 16'hFFFF;
            end
            rnd_item.now_ticks   = cur_now;
            rnd_item.has_message = ($urandom_range(0, 9) < 6);
            send_tick(rnd_item, 1'b0, '0);
         end
         quiet = 1'b0;
      end

      // Drain and let any stray item show up
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (150) @(posedge clock);
      if (err_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ----- phase_sync_oscillator_core.f -----
rtl/psync_pkg.sv
rtl/psync_if.sv
rtl/psync_div.sv
rtl/phase_sync_oscillator_core.sv
rtl/psync_checker.sv
tb/tb_phase_sync_oscillator_core.sv
